// ===== design/slxfr_pkg.sv =====
// Shared types and constants for the sync/length/XOR frame receiver.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package slxfr_pkg;

	// Depth of the frame store and the largest run of results one frame may give.
	localparam int STORE_DEPTH = 32;
	localparam int MAX_RESULTS = 31;

	// Largest body length that can still be delivered.
	localparam int FRAME_CAP = (STORE_DEPTH < MAX_RESULTS + 1) ? STORE_DEPTH : MAX_RESULTS + 1;

	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W  = $clog2(FRAME_CAP);

	localparam logic [7:0] STORE_DEPTH8 = 8'(STORE_DEPTH);
	localparam logic [7:0] FRAME_CAP8   = 8'(FRAME_CAP);
	localparam logic [7:0] SYNC_BYTE    = 8'h55;

	// Input function codes.
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Register index, taken from paddr bit 2.
	localparam logic REG_MAX_FRAME = 1'b0;
	localparam logic REG_TIMEOUT   = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_CHECKSUM = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_TIMEOUT  = 3'd3,
		ST_ZERO_LEN = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		EM_IDLE   = 2'd0,
		EM_STATUS = 2'd1,
		EM_READ   = 2'd2,
		EM_LOAD   = 2'd3
	} emit_state_t;

	// Request from the parser to the emitter at frame end.
	typedef struct packed {
		logic              valid;
		logic              run;
		status_t           status;
		logic [7:0]        length;
		logic [CNT_W-1:0]  count;
	} job_t;

	// Write port of the frame store.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

endpackage

`default_nettype wire

// ===== design/sync_length_xor_frame_receiver_core.sv =====
// Top level of the sync/length/XOR frame receiver: configuration registers
// on an APB-style port, parser, frame store and result emitter.
// Depends on slxfr_pkg, slxfr_parse, slxfr_store and slxfr_emit.
//
// Channel   Direction  Handshake                     Payload
// item      in         item_valid / item_ready       func, rx_byte
// result    out        result_valid / result_ready   status, data_byte, has_data, last,
//                                                    frame_length
// config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A tick or a byte that does not end a frame is taken while the emitter is idle,
// and the next item may follow in the next cycle.
// A frame that ends in a status result holds the input off while the emitter
// is in its status state, which it leaves once the output register is free;
// the status result then waits there while further items are taken.
// A good frame with payload holds the input off while its bytes are emitted:
// each byte passes through a frame-store read state and an output-register load
// state, and a load waits while the output register is stalled.
// Reset is asynchronous and needs no clearing pass; the store is only read
// at entries written during the current frame.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_xor_frame_receiver_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        func,
	input  wire logic [7:0]  rx_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic      [2:0]  status,
	output logic      [7:0]  data_byte,
	output logic             has_data,
	output logic             last,
	output logic      [7:0]  frame_length,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [5:0]  max_frame_q;
	logic [15:0] timeout_q;
	logic        cfg_write;

	slxfr_pkg::job_t job;
	slxfr_pkg::wr_t  wr;
	logic                         emit_busy;
	logic                         rd_en;
	logic [slxfr_pkg::ADDR_W-1:0] rd_addr;
	logic [7:0]                   rd_data;

	// Configuration registers.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= 6'd32;
			timeout_q   <= 16'd500;
		end else if (cfg_write) begin
			case (paddr[2])
				slxfr_pkg::REG_MAX_FRAME: max_frame_q <= pwdata[5:0];
				slxfr_pkg::REG_TIMEOUT:   timeout_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[2])
			slxfr_pkg::REG_MAX_FRAME: prdata = {26'd0, max_frame_q};
			slxfr_pkg::REG_TIMEOUT:   prdata = {16'd0, timeout_q};
			default:                  prdata = '0;
		endcase
	end

	slxfr_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.func       (func),
		.rx_byte    (rx_byte),
		.emit_busy  (emit_busy),
		.max_frame  (max_frame_q),
		.timeout    (timeout_q),
		.job        (job),
		.wr         (wr)
	);

	slxfr_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	slxfr_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job),
		.busy         (emit_busy),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.data_byte    (data_byte),
		.has_data     (has_data),
		.last         (last),
		.frame_length (frame_length)
	);

endmodule

`default_nettype wire

// ===== design/slxfr_store.sv =====
// Frame store: synchronous RAM, one write port and one registered read port.
// Depends on slxfr_pkg for its depth and the write port struct.
`timescale 1ns / 1ps
`default_nettype none

module slxfr_store (
	input  wire logic                          clk,
	input  wire slxfr_pkg::wr_t                wr,
	input  wire logic                          rd_en,
	input  wire logic [slxfr_pkg::ADDR_W-1:0]  rd_addr,
	output logic      [7:0]                    rd_data
);

	logic [7:0] mem [slxfr_pkg::STORE_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/slxfr_parse.sv =====
// Frame parser: sync hunt, length, body intake, running XOR and tick timer.
// Writes body bytes into the frame store and hands a request to the emitter
// at frame end. Depends on slxfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slxfr_parse (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire logic                func,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                emit_busy,
	input  wire logic [5:0]          max_frame,
	input  wire logic [15:0]         timeout,
	output slxfr_pkg::job_t          job,
	output slxfr_pkg::wr_t           wr
);

	slxfr_pkg::phase_t phase_q, phase_d;
	logic [7:0]  expected_q, expected_d;
	logic [7:0]  received_q, received_d;
	logic [7:0]  xor_q, xor_d;
	logic [15:0] idle_q, idle_d;

	logic        accept;
	logic        timed_out;
	logic [7:0]  recv_next;
	logic [7:0]  xor_next;
	logic        body_done;
	logic [7:0]  limit;

	// No new item while the emitter still works on the previous frame.
	assign item_ready = !emit_busy;
	assign accept     = item_valid && item_ready;

	assign timed_out = (idle_q >= timeout);
	assign recv_next = received_q + 8'd1;
	assign xor_next  = xor_q ^ rx_byte;
	assign body_done = (recv_next >= expected_q);
	assign limit     = ({2'b00, max_frame} < slxfr_pkg::FRAME_CAP8) ?
		{2'b00, max_frame} : slxfr_pkg::FRAME_CAP8;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (func == slxfr_pkg::FUNC_TICK) begin
				if (phase_q != slxfr_pkg::PH_HUNT && timed_out) begin
					phase_d = slxfr_pkg::PH_HUNT;
				end
			end else begin
				case (phase_q)
					slxfr_pkg::PH_HUNT: begin
						if (rx_byte == slxfr_pkg::SYNC_BYTE) begin
							phase_d = slxfr_pkg::PH_LEN;
						end
					end
					slxfr_pkg::PH_LEN: begin
						phase_d = (rx_byte == 8'd0) ? slxfr_pkg::PH_HUNT : slxfr_pkg::PH_BODY;
					end
					default: begin
						phase_d = body_done ? slxfr_pkg::PH_HUNT : slxfr_pkg::PH_BODY;
					end
				endcase
			end
		end
	end

	// Counters, store writes and the frame-end request.
	always_comb begin
		expected_d = expected_q;
		received_d = received_q;
		xor_d      = xor_q;
		idle_d     = idle_q;
		job        = '0;
		job.status = slxfr_pkg::ST_OK;
		job.length = expected_q;
		wr.en      = 1'b0;
		wr.addr    = received_q[slxfr_pkg::ADDR_W-1:0];
		wr.data    = rx_byte;
		if (accept) begin
			if (func == slxfr_pkg::FUNC_TICK) begin
				if (phase_q != slxfr_pkg::PH_HUNT) begin
					if (timed_out) begin
						job.valid  = 1'b1;
						job.status = slxfr_pkg::ST_TIMEOUT;
						job.length = (phase_q == slxfr_pkg::PH_LEN) ? 8'd0 : expected_q;
					end else begin
						idle_d = idle_q + 16'd1;
					end
				end
			end else begin
				case (phase_q)
					slxfr_pkg::PH_HUNT: begin
						if (rx_byte == slxfr_pkg::SYNC_BYTE) begin
							idle_d     = '0;
							expected_d = '0;
						end
					end
					slxfr_pkg::PH_LEN: begin
						idle_d     = '0;
						expected_d = rx_byte;
						received_d = '0;
						xor_d      = '0;
						if (rx_byte == 8'd0) begin
							job.valid  = 1'b1;
							job.status = slxfr_pkg::ST_ZERO_LEN;
							job.length = 8'd0;
						end
					end
					default: begin
						idle_d     = '0;
						xor_d      = xor_next;
						received_d = recv_next;
						wr.en      = (received_q < slxfr_pkg::STORE_DEPTH8);
						if (body_done) begin
							job.valid = 1'b1;
							if (expected_q > limit) begin
								job.status = slxfr_pkg::ST_TOO_LONG;
							end else if (xor_next != 8'd0) begin
								job.status = slxfr_pkg::ST_CHECKSUM;
							end else if (expected_q != 8'd1) begin
								// Good frame with payload: emit it as a run.
								job.run   = 1'b1;
								job.count = slxfr_pkg::CNT_W'(expected_q - 8'd1);
							end
						end
					end
				endcase
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= slxfr_pkg::PH_HUNT;
			expected_q <= '0;
			received_q <= '0;
			xor_q      <= '0;
			idle_q     <= '0;
		end else begin
			phase_q    <= phase_d;
			expected_q <= expected_d;
			received_q <= received_d;
			xor_q      <= xor_d;
			idle_q     <= idle_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/slxfr_emit.sv =====
// Result emitter: turns a frame-end request into one status result or a run
// of payload bytes read from the frame store, into an output register.
// Depends on slxfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slxfr_emit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire slxfr_pkg::job_t               job,
	output logic                               busy,
	output logic                               rd_en,
	output logic      [slxfr_pkg::ADDR_W-1:0]  rd_addr,
	input  wire logic [7:0]                    rd_data,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic      [2:0]                    status,
	output logic      [7:0]                    data_byte,
	output logic                               has_data,
	output logic                               last,
	output logic      [7:0]                    frame_length
);

	slxfr_pkg::emit_state_t state_q, state_d;

	logic [slxfr_pkg::CNT_W-1:0] idx_q;
	logic [slxfr_pkg::CNT_W-1:0] count_q;
	slxfr_pkg::status_t          job_status_q;
	logic [7:0]                  job_length_q;

	logic                        result_valid_q;
	slxfr_pkg::status_t          status_q;
	logic [7:0]                  data_byte_q;
	logic                        has_data_q;
	logic                        last_q;
	logic [7:0]                  frame_length_q;

	logic out_free;
	logic run_last;
	logic load_status;
	logic load_data;

	assign out_free = !result_valid_q || result_ready;
	assign run_last = (idx_q == (count_q - slxfr_pkg::CNT_W'(1)));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			slxfr_pkg::EM_IDLE: begin
				if (job.valid) begin
					state_d = job.run ? slxfr_pkg::EM_READ : slxfr_pkg::EM_STATUS;
				end
			end
			slxfr_pkg::EM_STATUS: begin
				if (out_free) begin
					state_d = slxfr_pkg::EM_IDLE;
				end
			end
			slxfr_pkg::EM_READ: begin
				state_d = slxfr_pkg::EM_LOAD;
			end
			slxfr_pkg::EM_LOAD: begin
				if (out_free) begin
					state_d = run_last ? slxfr_pkg::EM_IDLE : slxfr_pkg::EM_READ;
				end
			end
			default: begin
				state_d = slxfr_pkg::EM_IDLE;
			end
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		busy        = (state_q != slxfr_pkg::EM_IDLE);
		rd_en       = (state_q == slxfr_pkg::EM_READ);
		rd_addr     = slxfr_pkg::ADDR_W'(idx_q);
		load_status = (state_q == slxfr_pkg::EM_STATUS) && out_free;
		load_data   = (state_q == slxfr_pkg::EM_LOAD) && out_free;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= slxfr_pkg::EM_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_status || load_data) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Request capture and run index.
	always_ff @(posedge clk) begin
		if (state_q == slxfr_pkg::EM_IDLE && job.valid) begin
			idx_q        <= '0;
			count_q      <= job.count;
			job_status_q <= job.status;
			job_length_q <= job.length;
		end else if (load_data) begin
			idx_q <= idx_q + slxfr_pkg::CNT_W'(1);
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_status) begin
			status_q       <= job_status_q;
			data_byte_q    <= 8'd0;
			has_data_q     <= 1'b0;
			last_q         <= 1'b1;
			frame_length_q <= job_length_q;
		end else if (load_data) begin
			status_q       <= slxfr_pkg::ST_OK;
			data_byte_q    <= rd_data;
			has_data_q     <= 1'b1;
			last_q         <= run_last;
			frame_length_q <= job_length_q;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign data_byte    = data_byte_q;
	assign has_data     = has_data_q;
	assign last         = last_q;
	assign frame_length = frame_length_q;

	// A new request only arrives while the emitter is idle.
	a_job_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid |-> state_q == slxfr_pkg::EM_IDLE)
		else $error("frame-end request while emitter busy");

	// Every store read is followed by the load state that consumes its data.
	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == slxfr_pkg::EM_READ |=> state_q == slxfr_pkg::EM_LOAD)
		else $error("store read not followed by load");

	// Payload results always carry status OK.
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && has_data_q |-> status_q == slxfr_pkg::ST_OK)
		else $error("payload result with error status");

	// A result without payload is always the only result of its frame.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !has_data_q |-> last_q && data_byte_q == 8'd0)
		else $error("status result not marked last");

endmodule

`default_nettype wire

// ===== tb/sv/sync_length_xor_frame_receiver_core_test.sv =====
// Self-checking testbench for the sync/length/XOR frame receiver core.
// Holds its own predictor of the parser and emitter; depends on slxfr_pkg
// and sync_length_xor_frame_receiver_core.
`timescale 1ns / 1ps

module sync_length_xor_frame_receiver_core_test;
	import slxfr_pkg::*;

	// One input request and one result, at the widths of the ports.
	typedef struct packed {
		logic       f;
		logic [7:0] b;
	} rx_req_t;

	typedef struct packed {
		status_t    st;
		logic [7:0] data;
		logic       has_data;
		logic       last;
		logic [7:0] len;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	wire         item_ready;
	logic        func = FUNC_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	wire         result_valid;
	logic        result_ready = 1'b0;
	wire  [2:0]  status;
	wire  [7:0]  data_byte;
	wire         has_data;
	wire         last;
	wire  [7:0]  frame_length;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	wire  [31:0] prdata;
	wire         pready;

	// Register copies and receiver state as the block should hold them.
	logic [5:0]  cfg_max_frame = 6'd32;
	logic [15:0] cfg_timeout = 16'd500;
	phase_t      rx_phase = PH_HUNT;
	logic [7:0]  rx_len = 8'h00;
	logic [7:0]  rx_got = 8'h00;
	logic [7:0]  rx_xor = 8'h00;
	logic [15:0] rx_idle = 16'h0000;
	logic [7:0]  rx_store [STORE_DEPTH];

	rx_req_t       pending_reqs[$];
	frame_result_t due_results[$];
	int            mismatches = 0;
	logic [31:0]   cyc = 32'd0;
	wire           calm = (cyc[9:8] == 2'b11);

	sync_length_xor_frame_receiver_core DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.func(func), .rx_byte(rx_byte),
		.result_valid(result_valid), .result_ready(result_ready),
		.status(status), .data_byte(data_byte), .has_data(has_data),
		.last(last), .frame_length(frame_length),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 32'd1;
	end

	// Largest body length that still yields a payload run.
	function automatic int frame_cap();
		int lim;
		lim = cfg_max_frame;
		if (lim > STORE_DEPTH)
			lim = STORE_DEPTH;
		if (lim > MAX_RESULTS + 1)
			lim = MAX_RESULTS + 1;
		return lim;
	endfunction

	// Append one result to the list of those still due.
	function automatic void queue_result(input frame_result_t r);
		due_results.insert(due_results.size(), r);
	endfunction

	function automatic void expect_status(input status_t st, input logic [7:0] len);
		frame_result_t r;
		r = '{st, 8'h00, 1'b0, 1'b1, len};
		queue_result(r);
	endfunction

	// The last body byte is in: either the payload run or a single status.
	function automatic void close_frame();
		int n;
		int i;
		frame_result_t r;
		rx_phase = PH_HUNT;
		if (int'(rx_len) > frame_cap()) begin
			expect_status(ST_TOO_LONG, rx_len);
		end else if (rx_xor != 8'h00) begin
			expect_status(ST_CHECKSUM, rx_len);
		end else if (rx_len == 8'd1) begin
			expect_status(ST_OK, rx_len);
		end else begin
			n = int'(rx_len) - 1;
			for (i = 0; i < n; i++) begin
				r = '{ST_OK, rx_store[i], 1'b1, i == n - 1, rx_len};
				queue_result(r);
			end
		end
	endfunction

	// Advance the receiver by one accepted request.
	function automatic void absorb_request(input rx_req_t r);
		if (r.f == FUNC_TICK) begin
			if (rx_phase != PH_HUNT) begin
				if (rx_idle >= cfg_timeout) begin
					expect_status(ST_TIMEOUT, (rx_phase == PH_BODY) ? rx_len : 8'h00);
					rx_phase = PH_HUNT;
				end else begin
					rx_idle = rx_idle + 16'd1;
				end
			end
		end else if (rx_phase == PH_HUNT) begin
			if (r.b == SYNC_BYTE) begin
				rx_phase = PH_LEN;
				rx_idle = 16'h0000;
				rx_len = 8'h00;
			end
		end else if (rx_phase == PH_LEN) begin
			rx_idle = 16'h0000;
			rx_len = r.b;
			if (r.b == 8'h00) begin
				rx_phase = PH_HUNT;
				expect_status(ST_ZERO_LEN, 8'h00);
			end else begin
				rx_got = 8'h00;
				rx_xor = 8'h00;
				rx_phase = PH_BODY;
			end
		end else begin
			rx_idle = 16'h0000;
			if (rx_got < STORE_DEPTH)
				rx_store[rx_got] = r.b;
			rx_xor = rx_xor ^ r.b;
			rx_got = rx_got + 8'd1;
			if (rx_got >= rx_len)
				close_frame();
		end
	endfunction

	// Request driver: presents queued requests, idling at random outside calm stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				absorb_request({func, rx_byte});
			if (!item_valid || item_ready) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
					item_valid <= 1'b1;
					{func, rx_byte} <= pending_reqs.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: each accepted result is checked against the oldest one due.
	always @(posedge clk or negedge arst_n) begin : result_check
		frame_result_t seen;
		frame_result_t due;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				seen = '{status_t'(status), data_byte, has_data, last, frame_length};
				if (due_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: status %0d data %h has_data %b last %b length %0d",
							status, data_byte, has_data, last, frame_length);
					mismatches++;
				end else begin
					due = due_results.pop_front();
					if (seen !== due) begin
						if (mismatches < 10)
							$display("exp/act: st %0d/%0d data %h/%h hd %b/%b last %b/%b len %0d/%0d",
								due.st, seen.st, due.data, seen.data, due.has_data,
								seen.has_data, due.last, seen.last, due.len, seen.len);
						mismatches++;
					end
				end
			end
			result_ready <= calm || ($urandom_range(99) >= 17);
		end
	end

	task automatic send(input logic f, input logic [7:0] b);
		rx_req_t r;
		r = {f, b};
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic send_ticks(input int k);
		repeat (k) send(FUNC_TICK, 8'($urandom));
	endtask

	// Sync, length and body; abort_at >= 0 stalls the link long enough to time out there.
	task automatic send_frame(input int len, input bit good, input int abort_at);
		logic [7:0] sum;
		logic [7:0] v;
		int i;
		sum = 8'h00;
		send(FUNC_BYTE, SYNC_BYTE);
		send(FUNC_BYTE, 8'(len));
		for (i = 0; i < len; i++) begin
			if (i == abort_at) begin
				send_ticks(int'(cfg_timeout) + 1);
				return;
			end
			if ($urandom_range(7) == 0)
				send_ticks($urandom_range(1, (cfg_timeout < 4) ? cfg_timeout : 4));
			if (i < len - 1) begin
				case ($urandom_range(9))
					0: v = 8'h00;
					1: v = 8'hFF;
					default: v = 8'($urandom);
				endcase
				sum = sum ^ v;
			end else begin
				v = good ? sum : sum ^ 8'($urandom_range(1, 255));
			end
			send(FUNC_BYTE, v);
		end
	endtask

	// Mostly well-formed frames with random content, plus noise and broken frames.
	task automatic random_traffic(input int budget);
		int used;
		int kind;
		int len;
		int lim;
		int r;
		int cut;
		logic [7:0] v;
		used = 0;
		while (used < budget) begin
			lim = frame_cap();
			r = $urandom_range(99);
			if (r < 55)
				len = $urandom_range(1, (lim < 6) ? lim : 6);
			else if (r < 85)
				len = $urandom_range(1, lim);
			else if (r < 98)
				len = $urandom_range(lim + 1, lim + 4);
			else
				len = $urandom_range(33, 255);
			kind = $urandom_range(99);
			if (kind < 70) begin
				send_frame(len, $urandom_range(9) != 0, -1);
				used += len + 2;
			end else if (kind < 80 && cfg_timeout <= 40) begin
				cut = $urandom_range(0, len - 1);
				send_frame(len, 1'b1, cut);
				used += cut + int'(cfg_timeout) + 3;
			end else if (kind < 85) begin
				send_frame(0, 1'b1, -1);
				used += 2;
			end else if (kind < 88 && cfg_timeout <= 40) begin
				// Link goes quiet before the length byte arrives.
				send(FUNC_BYTE, SYNC_BYTE);
				send_ticks(int'(cfg_timeout) + 1);
				used += int'(cfg_timeout) + 2;
			end else if (kind < 95) begin
				// Line noise while hunting; a stray sync byte now and then.
				repeat ($urandom_range(1, 4)) begin
					v = 8'($urandom);
					if (v == SYNC_BYTE && $urandom_range(3) != 0)
						v = ~v;
					if ($urandom_range(2) == 0)
						send(FUNC_TICK, v);
					else
						send(FUNC_BYTE, v);
				end
			end else begin
				// Frame cut short; what follows is taken as its body.
				cut = $urandom_range(0, len - 1);
				send(FUNC_BYTE, SYNC_BYTE);
				send(FUNC_BYTE, 8'(len));
				repeat (cut) send(FUNC_BYTE, 8'($urandom));
				used += cut + 2;
			end
		end
	endtask

	// Hold off until every request is taken and every result has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || item_valid || due_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MAX_FRAME)
			cfg_max_frame = value[5:0];
		else
			cfg_timeout = value[15:0];
	endtask

	task automatic configure(input int max_bytes, input int ticks);
		write_reg(REG_MAX_FRAME, 32'(max_bytes));
		write_reg(REG_TIMEOUT, 32'(ticks));
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: noise while hunting, zero length, checksum-only frames and a short good frame.
		send(FUNC_BYTE, 8'h00);
		send(FUNC_TICK, 8'hFF);
		send(FUNC_BYTE, 8'hFF);
		send_frame(0, 1'b1, -1);
		send_frame(1, 1'b1, -1);
		send_frame(1, 1'b0, -1);
		send_frame(3, 1'b1, -1);
		wait_drained();

		// Tightest settings: oversize frame and timeouts before and inside the body.
		configure(1, 1);
		send_frame(2, 1'b1, -1);
		send(FUNC_BYTE, SYNC_BYTE);
		send_ticks(2);
		send_frame(255, 1'b1, 0);
		send_frame(5, 1'b1, 2);
		random_traffic(40);
		wait_drained();

		configure(32, 65535);
		random_traffic(75);
		wait_drained();

		configure($urandom_range(2, 31), 3);
		random_traffic(60);
		wait_drained();

		configure($urandom_range(1, 32), $urandom_range(2, 30));
		random_traffic(60);
		wait_drained();

		configure(32, 2);
		random_traffic(55);
		wait_drained();

		repeat (20) @(negedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : watchdog
		#2_400_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
